// ===== sv/lkt_pkg.sv =====
// Shared types, codes and constants of the keyed LRU table.
`default_nettype none

package lkt_pkg;

    // Default table depth
    localparam int LKT_MAX_ENTRIES = 16;

    // Field widths
    localparam int KEY_W  = 32;
    localparam int DATA_W = 64;
    localparam int CAP_W  = 5;

    // Configuration port geometry
    localparam int LKT_ADDR_W = 3;
    localparam int LKT_PDATA_W = 32;

    // Register indexes (paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] data;
    } rsp_t;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
    } lkt_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== sv/lru_keyed_table_core.sv =====
// Top level of the fully associative keyed table with LRU replacement.
//
//  channel   signals                                   transfer when
//  request   start, busy, req (req_type, key, value)   start && !busy at clk rise
//  result    done, rsp (found, data)                   done high, one cycle only
//  config    psel penable pwrite paddr pwdata prdata   psel && penable && pwrite
//
// One entry sweep reads the key, value and rank RAMs at one entry a cycle.
// Lookup, remove miss: busy for one match sweep over all MAX_ENTRIES entries.
// Insert, remove hit: busy for a match sweep, then a rank update sweep.
// Unused request code: no sweep. done is high in the first cycle with busy low.
// Reset clears the valid flags and the entry count at once; no clearing pass.
// The result receiver cannot stall; done lasts exactly one cycle.
`default_nettype none

module lru_keyed_table_core import lkt_pkg::*; #(
    parameter int MAX_ENTRIES = LKT_MAX_ENTRIES
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  req_t                        req,
    output logic                        busy,
    output logic                        done,
    output rsp_t                        rsp,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [LKT_ADDR_W-1:0]  paddr,
    input  wire logic [LKT_PDATA_W-1:0] pwdata,
    output logic      [LKT_PDATA_W-1:0] prdata,
    output logic                        pready
);

    lkt_cfg_t cfg;

    lkt_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lkt_engine #(.MAX_ENTRIES(MAX_ENTRIES)) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .cfg   (cfg),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== sv/lkt_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lkt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/lkt_apb.sv =====
// APB-style configuration register block of the keyed LRU table.
`default_nettype none

module lkt_apb import lkt_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [LKT_ADDR_W-1:0]  paddr,
    input  wire logic [LKT_PDATA_W-1:0] pwdata,
    output logic      [LKT_PDATA_W-1:0] prdata,
    output logic                        pready,
    output lkt_cfg_t                    cfg
);

    logic [CAP_W-1:0] capacity_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    // Capture capacity on a write transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (wr_en)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = LKT_PDATA_W'(capacity_reg);
        end
    end

    assign cfg.capacity = capacity_reg;

endmodule

`default_nettype wire

// ===== sv/lkt_engine.sv =====
// Sequencer and entry sweep unit of the keyed LRU table.
`default_nettype none

module lkt_engine import lkt_pkg::*; #(
    parameter int MAX_ENTRIES = LKT_MAX_ENTRIES
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  req_t      req,
    input  lkt_cfg_t  cfg,
    output logic      busy,
    output logic      done,
    output rsp_t      rsp
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [CW-1:0] LAST = CW'(MAX_ENTRIES);

    state_t                  state_reg, state_next;
    req_t                    req_reg;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           count_reg;
    logic [MAX_ENTRIES-1:0]  valid_reg;
    logic                    hit_reg;
    logic [AW-1:0]           hit_idx_reg;
    logic [AW-1:0]           hit_rank_reg;
    logic [DATA_W-1:0]       hit_value_reg;
    logic                    free_found_reg;
    logic [AW-1:0]           free_idx_reg;
    logic                    done_reg;
    rsp_t                    rsp_reg;

    logic [KEY_W-1:0]  key_rd;
    logic [AW-1:0]     rank_rd;
    logic [DATA_W-1:0] value_rd;

    logic              accept;
    logic              proc;
    logic              pass_end;
    logic [AW-1:0]     p_idx;
    logic              p_valid;
    logic              match;
    logic              evict;
    logic              is_ins, is_rem, is_lk;
    logic [EW-1:0]     cap_ext;
    logic [EW-1:0]     effcap_ext;
    logic [CW-1:0]     effcap;
    logic [CW-1:0]     effcap_m1;
    logic [AW-1:0]     raddr;

    logic              rank_we, key_we, value_we;
    logic [AW-1:0]     rank_waddr, key_waddr, value_waddr;
    logic [AW-1:0]     rank_wdata;

    // Clamp the configured capacity to 1..MAX_ENTRIES
    always_comb
    begin
        cap_ext = EW'(cfg.capacity);
        if (cap_ext == '0)
        begin
            effcap_ext = EW'(1);
        end
        else if (cap_ext > EW'(MAX_ENTRIES))
        begin
            effcap_ext = EW'(MAX_ENTRIES);
        end
        else
        begin
            effcap_ext = cap_ext;
        end
    end

    assign effcap    = CW'(effcap_ext);
    assign effcap_m1 = effcap - CW'(1);

    // Sweep decode: entry p_idx has its RAM data this cycle
    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign proc     = (cnt_reg != '0);
    assign pass_end = (cnt_reg == LAST);
    assign p_idx    = AW'(cnt_reg - CW'(1));
    assign p_valid  = valid_reg[p_idx];
    assign raddr    = cnt_reg[AW-1:0];
    assign is_ins   = (req_reg.req_type == REQ_INSERT);
    assign is_rem   = (req_reg.req_type == REQ_REMOVE);
    assign is_lk    = (req_reg.req_type == REQ_LOOKUP);
    assign match    = proc && p_valid && (key_rd == req_reg.key);
    assign evict    = is_ins && !hit_reg && p_valid && (CW'(rank_rd) >= effcap_m1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_INSERT, REQ_REMOVE, REQ_LOOKUP: state_next = ST_SCAN;
                        default:                            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (pass_end)
                begin
                    if (is_ins || (is_rem && (hit_reg || match)))
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_UPDATE:
            begin
                if (pass_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM write ports
    always_comb
    begin
        rank_we     = 1'b0;
        rank_waddr  = free_idx_reg;
        rank_wdata  = '0;
        key_we      = 1'b0;
        key_waddr   = free_idx_reg;
        value_we    = 1'b0;
        value_waddr = hit_reg ? hit_idx_reg : free_idx_reg;
        if (state_reg == ST_UPDATE)
        begin
            rank_we    = proc;
            rank_waddr = p_idx;
            if (is_rem)
            begin
                rank_wdata = (rank_rd > hit_rank_reg) ? rank_rd - AW'(1) : rank_rd;
            end
            else if (hit_reg)
            begin
                if (p_idx == hit_idx_reg)
                begin
                    rank_wdata = '0;
                end
                else
                begin
                    rank_wdata = (rank_rd < hit_rank_reg) ? rank_rd + AW'(1) : rank_rd;
                end
            end
            else
            begin
                rank_wdata = rank_rd + AW'(1);
            end
        end
        else if (state_reg == ST_FINISH)
        begin
            value_we = is_ins;
            key_we   = is_ins && !hit_reg;
            rank_we  = is_ins && !hit_reg;
        end
    end

    // Control state and sweep bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            count_reg      <= '0;
            valid_reg      <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FINISH);
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg        <= '0;
                    hit_reg        <= 1'b0;
                    free_found_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    cnt_reg <= pass_end ? '0 : cnt_reg + CW'(1);
                    if (match)
                    begin
                        hit_reg <= 1'b1;
                    end
                end
                ST_UPDATE:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (proc)
                    begin
                        if (evict)
                        begin
                            valid_reg[p_idx] <= 1'b0;
                        end
                        if (!free_found_reg && !(p_valid && !evict))
                        begin
                            free_found_reg <= 1'b1;
                        end
                    end
                end
                ST_FINISH:
                begin
                    cnt_reg <= '0;
                    if (is_ins && !hit_reg)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        count_reg <= (count_reg >= effcap) ? effcap : count_reg + CW'(1);
                    end
                    else if (is_rem && hit_reg)
                    begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                        count_reg <= count_reg - CW'(1);
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    // Payload registers: request, hit details, free slot, result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if ((state_reg == ST_SCAN) && match)
        begin
            hit_idx_reg   <= p_idx;
            hit_rank_reg  <= rank_rd;
            hit_value_reg <= value_rd;
        end
        if ((state_reg == ST_UPDATE) && proc && !free_found_reg && !(p_valid && !evict))
        begin
            free_idx_reg <= p_idx;
        end
        if (state_reg == ST_FINISH)
        begin
            rsp_reg.found <= is_lk && hit_reg;
            rsp_reg.data  <= (is_lk && hit_reg) ? hit_value_reg : '0;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Entry storage
    lkt_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (req_reg.key),
        .raddr (raddr),
        .rdata (key_rd)
    );

    lkt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ENTRIES)) u_value_ram (
        .clk   (clk),
        .we    (value_we),
        .waddr (value_waddr),
        .wdata (req_reg.value),
        .raddr (raddr),
        .rdata (value_rd)
    );

    lkt_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (raddr),
        .rdata (rank_rd)
    );

endmodule

`default_nettype wire

// ===== sv/lkt_checker.sv =====
// Port-level assertions of the keyed LRU table and their bind.
`default_nettype none

module lkt_checker import lkt_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input rsp_t      rsp,
    input wire logic pready
);

    // A result is delivered only once the block is free again
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not raise busy");

    // Each result strobe stands alone
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // A miss or a non-lookup result carries zero data
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.found) |-> (rsp.data == '0))
        else $error("nonzero data without found");

    // Configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind lru_keyed_table_core lkt_checker u_lkt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .rsp    (rsp),
    .pready (pready)
);

`default_nettype wire

// ===== bench/tb_lru_keyed_table_core.sv =====
// Self-checking bench for the keyed LRU table core with a tracking scoreboard.
`default_nettype none

module tb_lru_keyed_table_core import lkt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEMS_PER_PHASE = 143;
    localparam int DRAIN_CYCLES = 2 * LKT_MAX_ENTRIES + 8;
    localparam int POOL_SIZE = 24;
    localparam logic [LKT_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

    // Track table contents and recency, hold the results each request must give
    class table_tracker;
        logic [CAP_W-1:0]  capacity;
        logic [KEY_W-1:0]  slot_key[LKT_MAX_ENTRIES];
        logic [DATA_W-1:0] slot_value[LKT_MAX_ENTRIES];
        bit                slot_live[LKT_MAX_ENTRIES];
        int                slot_age[LKT_MAX_ENTRIES];
        int                live_count;
        rsp_t              pending_rsp[$];
        int                errors;

        function new();
            capacity = CAP_RESET;
            live_count = 0;
            errors = 0;
            for (int i = 0; i < LKT_MAX_ENTRIES; i++)
            begin
                slot_key[i] = '0;
                slot_value[i] = '0;
                slot_live[i] = 1'b0;
                slot_age[i] = 0;
            end
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function int eff_capacity();
            if (capacity < 1)
                return 1;
            if (capacity > LKT_MAX_ENTRIES)
                return LKT_MAX_ENTRIES;
            return int'(capacity);
        endfunction

        function int find_slot(logic [KEY_W-1:0] k);
            for (int i = 0; i < LKT_MAX_ENTRIES; i++)
                if (slot_live[i] && slot_key[i] == k)
                    return i;
            return -1;
        endfunction

        // Free a slot and close the gap it leaves in the age order
        function void free_slot(int s);
            int r;
            r = slot_age[s];
            for (int i = 0; i < LKT_MAX_ENTRIES; i++)
                if (slot_live[i] && slot_age[i] > r)
                    slot_age[i]--;
            slot_live[s] = 1'b0;
            slot_age[s] = 0;
            if (live_count > 0)
                live_count--;
        endfunction

        function void evict_oldest();
            int victim;
            int best;
            victim = -1;
            best = 0;
            for (int i = 0; i < LKT_MAX_ENTRIES; i++)
                if (slot_live[i] && (victim < 0 || slot_age[i] > best))
                begin
                    victim = i;
                    best = slot_age[i];
                end
            if (victim >= 0)
                free_slot(victim);
            else
                live_count = 0;
        endfunction

        function void store_pair(logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
            int s;
            int r;
            s = find_slot(k);
            // Refresh a present key: make it most recent
            if (s >= 0)
            begin
                r = slot_age[s];
                for (int i = 0; i < LKT_MAX_ENTRIES; i++)
                    if (slot_live[i] && slot_age[i] < r)
                        slot_age[i]++;
                slot_age[s] = 0;
                slot_value[s] = v;
                return;
            end
            // Make room under the capacity, then take the first free slot
            while (live_count >= eff_capacity())
                evict_oldest();
            for (int i = 0; i < LKT_MAX_ENTRIES; i++)
                if (!slot_live[i])
                begin
                    s = i;
                    break;
                end
            if (s < 0)
                return;
            for (int i = 0; i < LKT_MAX_ENTRIES; i++)
                if (slot_live[i])
                    slot_age[i]++;
            slot_live[s] = 1'b1;
            slot_key[s] = k;
            slot_value[s] = v;
            slot_age[s] = 0;
            live_count++;
        endfunction

        // Apply an accepted request and queue the result it must produce
        function void note_request(req_t r);
            rsp_t res;
            int s;
            res = '0;
            case (r.req_type)
                REQ_INSERT: store_pair(r.key, r.value);
                REQ_REMOVE:
                begin
                    s = find_slot(r.key);
                    if (s >= 0)
                        free_slot(s);
                end
                REQ_LOOKUP:
                begin
                    s = find_slot(r.key);
                    if (s >= 0)
                    begin
                        res.found = 1'b1;
                        res.data = slot_value[s];
                    end
                end
                default: ;
            endcase
            pending_rsp.push_back(res);
        endfunction

        // Compare a result with the oldest queued one
        function void check_response(rsp_t got);
            rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: result with no request waiting, found %0b data %h",
                         $time, got.found, got.data);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: found mismatch, expected %0b actual %0b",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.data !== want.data)
            begin
                $display("%0t: data mismatch, expected %h actual %h",
                         $time, want.data, got.data);
                errors++;
            end
        endfunction

        function int pending();
            return pending_rsp.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    req_t                   req = '0;
    logic                   busy;
    logic                   done;
    rsp_t                   rsp;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [LKT_ADDR_W-1:0]  paddr = '0;
    logic [LKT_PDATA_W-1:0] pwdata = '0;
    logic [LKT_PDATA_W-1:0] prdata;
    logic                   pready;

    table_tracker sb = new();
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    int cycle_count = 0;

    lru_keyed_table_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lru_keyed_table_core test failed");
            $finish;
        end
    end

    // Check each result and record each request transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_response(rsp);
            if (start && !busy)
                sb.note_request(req);
        end
    end

    function automatic req_t make_req(logic [1:0] kind, logic [KEY_W-1:0] k,
                                      logic [DATA_W-1:0] v);
        req_t r;
        r.req_type = kind;
        r.key = k;
        r.value = v;
        return r;
    endfunction

    // Favor keys from a small pool so inserts, hits and evictions interleave
    function automatic req_t random_request(int pool_hi);
        req_t r;
        int sel;
        sel = $urandom_range(99);
        if (sel < 42)
            r.req_type = REQ_INSERT;
        else if (sel < 62)
            r.req_type = REQ_REMOVE;
        else if (sel < 96)
            r.req_type = REQ_LOOKUP;
        else
            r.req_type = REQ_UNUSED;
        if ($urandom_range(99) < 90)
            r.key = key_pool[$urandom_range(pool_hi)];
        else
            r.key = $urandom;
        r.value = {$urandom, $urandom};
        return r;
    endfunction

    // Present one request, idling first at the given rate, and hold until transfer
    task automatic send_request(req_t r, int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            req <= {2'($urandom), $urandom, $urandom, $urandom};
            repeat ($urandom_range(1, DRAIN_CYCLES)) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and wait for every queued result
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        logic [LKT_PDATA_W-1:0] word;
        word = $urandom;
        word[CAP_W-1:0] = cap;
        drain_results();
        repeat (4) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= CAPACITY_ADDR;
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_capacity(word[CAP_W-1:0]);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_directed();
        // Empty table: zero key of cleared slots must not match
        send_request(make_req(REQ_LOOKUP, 32'h0, 64'h0), 0);
        send_request(make_req(REQ_REMOVE, 32'h0, '1), 0);
        send_request(make_req(REQ_UNUSED, '1, '1), 0);
        // Extreme keys and payloads
        send_request(make_req(REQ_INSERT, 32'h0, '1), 0);
        send_request(make_req(REQ_INSERT, '1, 64'h0), 0);
        send_request(make_req(REQ_LOOKUP, 32'h0, 64'h0), 0);
        send_request(make_req(REQ_LOOKUP, '1, '1), 0);
        // Refresh a present key
        send_request(make_req(REQ_INSERT, 32'h0, 64'h0123_4567_89ab_cdef), 0);
        send_request(make_req(REQ_LOOKUP, 32'h0, 64'h0), 0);
        // Remove, then remove again while absent
        send_request(make_req(REQ_REMOVE, 32'h0, 64'h0), 0);
        send_request(make_req(REQ_LOOKUP, 32'h0, 64'h0), 0);
        send_request(make_req(REQ_REMOVE, 32'h0, 64'h0), 0);
        send_request(make_req(REQ_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0001), 0);
        send_request(make_req(REQ_LOOKUP, 32'h8000_0000, 64'h0), 0);
        send_request(make_req(REQ_LOOKUP, 32'h0000_0001, 64'h0), 0);
        send_request(make_req(REQ_INSERT, 32'h1234_5678, 64'h5555_aaaa_5555_aaaa), 0);
        // Capacity lowered below the count: next new key evicts down to room
        write_capacity(5'd1);
        send_request(make_req(REQ_LOOKUP, 32'h1234_5678, 64'h0), 0);
        send_request(make_req(REQ_INSERT, 32'h0000_0055, 64'h0000_0000_0000_00aa), 0);
        send_request(make_req(REQ_LOOKUP, '1, 64'h0), 0);
        send_request(make_req(REQ_LOOKUP, 32'h8000_0000, 64'h0), 0);
        send_request(make_req(REQ_LOOKUP, 32'h0000_0055, 64'h0), 0);
        // Capacity zero acts as one
        write_capacity(5'd0);
        send_request(make_req(REQ_INSERT, 32'h0000_0066, 64'h1), 0);
        send_request(make_req(REQ_LOOKUP, 32'h0000_0055, 64'h0), 0);
        send_request(make_req(REQ_LOOKUP, 32'h0000_0066, 64'h0), 0);
    endtask

    initial
    begin
        logic [CAP_W-1:0] phase_cap[10];
        int idle_pct;
        int pool_hi;
        phase_cap = '{5'd16, 5'd31, 5'd5, 5'd1, 5'd16, 5'd9, 5'd17, 5'd2, 5'd0, 5'd16};
        key_pool[0] = 32'h0;
        key_pool[1] = '1;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h0000_0001;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Random phases: sender idles at 14, then 46 percent, then never
        for (int p = 0; p < 10; p++)
        begin
            idle_pct = (p < 4) ? 14 : (p < 7) ? 46 : 0;
            write_capacity(phase_cap[p]);
            pool_hi = sb.eff_capacity() + 3;
            if (pool_hi > POOL_SIZE - 1)
                pool_hi = POOL_SIZE - 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_request(random_request(pool_hi), idle_pct);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d results never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("lru_keyed_table_core test passed");
        else
            $display("lru_keyed_table_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
